// File: src/s3tc_pkg.sv
// ----------------------------------------------------------------------------
// s3tc_pkg
// Shared types, register codes and constant-divide helpers for the S3TC
// block decoder.
// ----------------------------------------------------------------------------
package s3tc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_FORMAT = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // block format codes (code three decodes as BC1)
    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    localparam int DIM_W = 15;

    // block after endpoint expansion and clipping
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [2:0]  ncols;
        logic [2:0]  nrows;
        logic        three;
        logic [1:0][23:0] ends;   // {r,g,b} of c0 and c1
        logic [31:0] cidx;
        logic [63:0] aw;
    } exp_blk_t;

    // block with full palettes
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [2:0]  ncols;
        logic [2:0]  nrows;
        logic        three;
        logic [3:0][23:0] cpal;
        logic [7:0][7:0]  apal;
        logic [31:0] cidx;
        logic [63:0] aw;
    } dec_blk_t;

    // emitter status seen by the top level
    typedef struct packed {
        logic       busy;
        logic       fire;
        logic       last;
        logic [1:0] px;
        logic [1:0] py;
        logic [2:0] ncols;
        logic [2:0] nrows;
    } emit_status_t;

    // v*255/31, truncated: reciprocal multiply, exact for all 5-bit v
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [25:0] p;
        p = {21'b0, v} * 26'd2156535;
        return p[25:18];
    endfunction

    // v*255/63, truncated
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [27:0] p;
        p = {22'b0, v} * 28'd4244475;
        return p[27:20];
    endfunction

    // x/3 for x < 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = {11'b0, x} * 21'd683;
        return p[18:11];
    endfunction

    // x/5 for x <= 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [20:0] p;
        p = {10'b0, x} * 21'd1639;
        return p[20:13];
    endfunction

    // x/7 for x <= 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [21:0] p;
        p = {11'b0, x} * 22'd2341;
        return p[21:14];
    endfunction

endpackage

// File: src/s3tc_front.sv
// ----------------------------------------------------------------------------
// s3tc_front
// Input register and endpoint stage: RGB565 expansion, palette mode and
// visible row/column counts of the block.
// ----------------------------------------------------------------------------
module s3tc_front
    import s3tc_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = 16384
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       fmt,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [11:0]      block_col,
    input  logic [11:0]      block_row,
    input  logic [63:0]      alpha_word,
    input  logic [63:0]      color_word,
    output logic             blk_valid,
    input  logic             blk_take,
    output exp_blk_t         blk
);

    localparam logic [16:0] MAX_DIM = 17'(MAX_IMAGE_DIM);

    logic        a_valid_reg, a_valid_next;
    logic [11:0] a_col_reg, a_row_reg;
    logic [63:0] a_aw_reg, a_cw_reg;
    logic        b_valid_reg, b_valid_next;
    exp_blk_t    b_blk_reg, b_blk_next;
    logic        b_ready, a_ready, a_load;
    logic [15:0] c0, c1;
    logic [13:0] x0, y0;
    logic [3:0]  vis_x, vis_y;

    assign b_ready  = !b_valid_reg || blk_take;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;
    assign a_load   = in_valid && a_ready;

    always_comb
    begin
        c0 = a_cw_reg[15:0];
        c1 = a_cw_reg[31:16];
        x0 = {a_col_reg, 2'b00};
        y0 = {a_row_reg, 2'b00};
        for (int i = 0; i < 4; i++)
        begin
            vis_x[i] = ({3'b0, x0 + 14'(i)} < {2'b0, width})
                    && ({3'b0, x0 + 14'(i)} < MAX_DIM);
            vis_y[i] = ({3'b0, y0 + 14'(i)} < {2'b0, height})
                    && ({3'b0, y0 + 14'(i)} < MAX_DIM);
        end
        b_blk_next.col   = a_col_reg;
        b_blk_next.row   = a_row_reg;
        // visible columns form a prefix of the block
        b_blk_next.ncols = vis_x[3] ? 3'd4 : vis_x[2] ? 3'd3 : vis_x[1] ? 3'd2
                         : vis_x[0] ? 3'd1 : 3'd0;
        b_blk_next.nrows = vis_y[3] ? 3'd4 : vis_y[2] ? 3'd3 : vis_y[1] ? 3'd2
                         : vis_y[0] ? 3'd1 : 3'd0;
        b_blk_next.three = (fmt != FMT_BC2) && (fmt != FMT_BC3) && !(c0 > c1);
        b_blk_next.ends[0] = {expand5(c0[15:11]), expand6(c0[10:5]), expand5(c0[4:0])};
        b_blk_next.ends[1] = {expand5(c1[15:11]), expand6(c1[10:5]), expand5(c1[4:0])};
        b_blk_next.cidx  = a_cw_reg[63:32];
        b_blk_next.aw    = a_aw_reg;
        a_valid_next = a_load ? 1'b1 : (b_ready ? 1'b0 : a_valid_reg);
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_col_reg <= block_col;
            a_row_reg <= block_row;
            a_aw_reg  <= alpha_word;
            a_cw_reg  <= color_word;
        end
        if (b_ready && a_valid_reg)
        begin
            b_blk_reg <= b_blk_next;
        end
    end

    assign blk_valid = b_valid_reg;
    assign blk       = b_blk_reg;

endmodule

// File: src/s3tc_palette.sv
// ----------------------------------------------------------------------------
// s3tc_palette
// Interpolated colour entries (four- or three-colour) and the BC3 alpha
// palette (eight- or six-value).
// ----------------------------------------------------------------------------
module s3tc_palette
    import s3tc_pkg::*;
(
    input  exp_blk_t blk_in,
    output dec_blk_t blk_out
);

    logic [7:0] e0, e1, a0, a1;
    logic [8:0] half_sum;

    always_comb
    begin
        blk_out.col   = blk_in.col;
        blk_out.row   = blk_in.row;
        blk_out.ncols = blk_in.ncols;
        blk_out.nrows = blk_in.nrows;
        blk_out.three = blk_in.three;
        blk_out.cidx  = blk_in.cidx;
        blk_out.aw    = blk_in.aw;
        blk_out.cpal[0] = blk_in.ends[0];
        blk_out.cpal[1] = blk_in.ends[1];
        e0 = 8'd0;
        e1 = 8'd0;
        half_sum = 9'd0;
        // channels are independent: r, g, b
        for (int ch = 0; ch < 3; ch++)
        begin
            e0 = blk_in.ends[0][ch*8 +: 8];
            e1 = blk_in.ends[1][ch*8 +: 8];
            if (blk_in.three)
            begin
                half_sum = {1'b0, e0} + {1'b0, e1};
                blk_out.cpal[2][ch*8 +: 8] = half_sum[8:1];
                blk_out.cpal[3][ch*8 +: 8] = 8'd0;
            end
            else
            begin
                blk_out.cpal[2][ch*8 +: 8] = div3({1'b0, e0, 1'b0} + {2'b0, e1});
                blk_out.cpal[3][ch*8 +: 8] = div3({2'b0, e0} + {1'b0, e1, 1'b0});
            end
        end

        a0 = blk_in.aw[7:0];
        a1 = blk_in.aw[15:8];
        blk_out.apal[0] = a0;
        blk_out.apal[1] = a1;
        for (int i = 1; i <= 6; i++)
        begin
            if (a0 > a1)
            begin
                blk_out.apal[1 + i] = div7(11'(7 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1});
            end
            else if (i <= 4)
            begin
                blk_out.apal[1 + i] = div5(11'(5 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1});
            end
            else
            begin
                blk_out.apal[1 + i] = (i == 5) ? 8'd0 : 8'd255;
            end
        end
    end

endmodule

// File: src/s3tc_emitter.sv
// ----------------------------------------------------------------------------
// s3tc_emitter
// Holds one decoded block and walks its visible pixels, one word per cycle
// while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module s3tc_emitter
    import s3tc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   fmt,
    input  logic         blk_valid,
    output logic         blk_ready,
    input  dec_blk_t     blk,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [13:0]  pixel_x,
    output logic [13:0]  pixel_y,
    output logic [7:0]   red,
    output logic [7:0]   green,
    output logic [7:0]   blue,
    output logic [7:0]   alpha,
    output logic         last_pixel,
    output emit_status_t status
);

    logic        busy_reg, busy_next;
    logic [1:0]  px_reg, px_next, py_reg, py_next;
    dec_blk_t    blk_reg;
    logic        o_valid_reg, o_valid_next;
    logic [13:0] x_reg, y_reg;
    logic [7:0]  r_reg, g_reg, b_reg, a_reg;
    logic        last_reg;
    logic [3:0]  p;
    logic [1:0]  ci;
    logic [3:0]  nib;
    logic [2:0]  ai;
    logic [23:0] rgb;
    logic [7:0]  a_sel;
    logic        row_end, last, fire, load;

    always_comb
    begin
        p   = {py_reg, px_reg};
        ci  = blk_reg.cidx[{p, 1'b0} +: 2];
        nib = blk_reg.aw[{p, 2'b00} +: 4];
        ai  = blk_reg.aw[6'({p, 1'b0}) + 6'(p) + 6'd16 +: 3];
        rgb = blk_reg.cpal[ci];
        unique case (fmt)
            FMT_BC2: a_sel = {nib, nib};
            FMT_BC3: a_sel = blk_reg.apal[ai];
            default: a_sel = (blk_reg.three && ci == 2'd3) ? 8'd0 : 8'd255;
        endcase

        row_end = ({1'b0, px_reg} + 3'd1) == blk_reg.ncols;
        last    = row_end && (({1'b0, py_reg} + 3'd1) == blk_reg.nrows);
        fire    = busy_reg && (!o_valid_reg || !out_stall);
        blk_ready = !busy_reg || (fire && last);
        load    = blk_valid && blk_ready;

        busy_next = busy_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        if (fire && last)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            // fully clipped blocks are dropped here
            busy_next = (blk.ncols != 3'd0) && (blk.nrows != 3'd0);
        end
        if (load || (fire && last))
        begin
            px_next = 2'd0;
            py_next = 2'd0;
        end
        else if (fire)
        begin
            if (row_end)
            begin
                px_next = 2'd0;
                py_next = py_reg + 2'd1;
            end
            else
            begin
                px_next = px_reg + 2'd1;
            end
        end

        o_valid_next = (!o_valid_reg || !out_stall) ? fire : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            px_reg      <= 2'd0;
            py_reg      <= 2'd0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blk_reg <= blk;
        end
        if (fire)
        begin
            x_reg    <= {blk_reg.col, px_reg};
            y_reg    <= {blk_reg.row, py_reg};
            r_reg    <= rgb[23:16];
            g_reg    <= rgb[15:8];
            b_reg    <= rgb[7:0];
            a_reg    <= a_sel;
            last_reg <= last;
        end
    end

    assign out_valid  = o_valid_reg;
    assign pixel_x    = x_reg;
    assign pixel_y    = y_reg;
    assign red        = r_reg;
    assign green      = g_reg;
    assign blue       = b_reg;
    assign alpha      = a_reg;
    assign last_pixel = last_reg;

    assign status.busy  = busy_reg;
    assign status.fire  = fire;
    assign status.last  = last;
    assign status.px    = px_reg;
    assign status.py    = py_reg;
    assign status.ncols = blk_reg.ncols;
    assign status.nrows = blk_reg.nrows;

endmodule

// File: src/s3tc_block_decoder_top.sv
// ----------------------------------------------------------------------------
// s3tc_block_decoder_top
// S3TC (BC1/BC2/BC3) block decoder: one compressed 4x4 block in, its
// visible pixels out as RGBA8 in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one block word: block column,
//   block row, alpha half and colour half. Output channel
//   (out_valid/out_stall) gives one pixel word per handshake, with its image
//   position; last_pixel marks the final visible pixel of the block.
//   Pixels beyond image_width/image_height are skipped; a block with no
//   visible pixel produces no word at all.
//   A block's first pixel passes the input, endpoint, emitter block and output
//   registers. Pixel words leave at one per cycle while out_stall is low,
//   a block giving one word per visible pixel (16 for an interior block),
//   as the pixel walker in the emitter steps. Up to two further blocks
//   wait in the input and endpoint registers meanwhile.
//   The user writes configuration (cfg_wr_en/cfg_index/cfg_data) only while idle; the block does not enforce it.
//   Reset: format BC1, width and height 1, all pipeline stages empty.
//   A stalled receiver holds the output word; back-pressure then ripples
//   up to in_stall once every stage is full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module s3tc_block_decoder_top
    import s3tc_pkg::*;
#(
    parameter int MAX_IMAGE_DIM = 16384
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    // block input
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [11:0]      block_col,
    input  logic [11:0]      block_row,
    input  logic [63:0]      alpha_word,
    input  logic [63:0]      color_word,
    // pixel output
    output logic             out_valid,
    input  logic             out_stall,
    output logic [13:0]      pixel_x,
    output logic [13:0]      pixel_y,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic [7:0]       alpha,
    output logic             last_pixel
);

    logic [1:0]       fmt_reg;
    logic [DIM_W-1:0] width_reg, height_reg;

    exp_blk_t     exp_blk;
    dec_blk_t     dec_blk;
    logic         exp_valid, emit_ready;
    emit_status_t emit_st;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_BC1;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BLOCK_FORMAT: fmt_reg    <= cfg_data[1:0];
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stages 1-2: input capture, endpoint expansion, clipping
    s3tc_front #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fmt        (fmt_reg),
        .width      (width_reg),
        .height     (height_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .block_col  (block_col),
        .block_row  (block_row),
        .alpha_word (alpha_word),
        .color_word (color_word),
        .blk_valid  (exp_valid),
        .blk_take   (emit_ready),
        .blk        (exp_blk)
    );

    // palette interpolation, registered at the emitter's block register
    s3tc_palette u_palette (
        .blk_in  (exp_blk),
        .blk_out (dec_blk)
    );

    // stage 3-4: pixel walk and output register
    s3tc_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .fmt        (fmt_reg),
        .blk_valid  (exp_valid),
        .blk_ready  (emit_ready),
        .blk        (dec_blk),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel),
        .status     (emit_st)
    );

    // walker always stays inside the visible rectangle
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_st.busy |-> (({1'b0, emit_st.px} < emit_st.ncols)
                       && ({1'b0, emit_st.py} < emit_st.nrows)))
        else $error("pixel walker outside visible rectangle");

    // a block's last pixel resets the walker
    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_st.fire && emit_st.last) |=> (emit_st.px == 2'd0 && emit_st.py == 2'd0))
        else $error("walker not restarted after last pixel");

    // block stays held until its last pixel is sent
    a_block_held: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_st.fire && !emit_st.last) |=> emit_st.busy)
        else $error("block dropped before its last pixel");

    // every emitted pixel reaches the output register
    a_fire_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit_st.fire |=> out_valid)
        else $error("emitted pixel missing at output");

endmodule
